@@ src/tcw_pkg.sv @@
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int CHAR_W = 8;
    localparam int CELL_W = 2 * CHAR_W;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int CUR_W  = $clog2(CELLS + 1);
    localparam int SUM_W  = CUR_W + 1;
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_ATTR = 8'h07;

    localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, CHAR_NUL};

endpackage

@@ src/tcw_if.sv @@
interface tcw_cmd_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [CHAR_W-1:0] char_code;
    logic              last_of_write;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, command, char_code, last_of_write, cell_index,
                    input ready);
    modport sink   (input valid, command, char_code, last_of_write, cell_index,
                    output ready);
endinterface

interface tcw_res_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  cursor_pos;
    logic              cursor_update;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;

    modport source (output valid, cursor_pos, cursor_update, cell_char, cell_attr,
                    input ready);
    modport sink   (input valid, cursor_pos, cursor_update, cell_char, cell_attr,
                    output ready);
endinterface

@@ src/tcw_ram.sv @@
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/text_console_char_writer_core.sv @@
// Text console character writer: a screen of COLUMNS x ROWS cells (char in the
// low byte, attribute in the high byte) held in one RAM, and a linear cursor.
// cmd carries one beat per command: a put of one byte, or a read of one cell.
// res returns exactly one beat per command: the cursor after the command, the
// cursor-update flag (put with last_of_write set) and, for a read, the cell.
// Commands run one at a time under a small sequencer around the screen RAM
// (one write and one registered read port per cycle).
// Path from cmd beat to res valid: NUL, a newline without scroll, backspace
// at zero and a read outside the screen go straight to the finish state; a
// read of a cell passes a capture state; a printable byte or backspace reads,
// then writes the cell. A scroll, where needed, comes first: one row-up copy
// of a cell per cycle, RAM read and write overlapped, then the bottom row filled.
// cmd.ready is high only while the sequencer is idle; the next beat is taken
// in the cycle res goes valid, so a new command waits for the last to finish.
// After reset the RAM is cleared one cell per cycle, all CELLS cells (2000),
// with cmd.ready low. The result sits in an output register: a stalled res
// does not block the next command, which waits only if it finishes while the
// previous beat is still untaken.
module text_console_char_writer_core import tcw_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    tcw_cmd_if.sink   cmd,
    tcw_res_if.source res
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_PUT_RD = 3'd4;
    localparam logic [2:0] ST_PUT_WR = 3'd5;
    localparam logic [2:0] ST_RD_CAP = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    localparam logic [CUR_W-1:0] CELLS_C = CUR_W'(CELLS);
    localparam logic [CUR_W-1:0] COPY_C  = CUR_W'(CELLS - COLUMNS);
    localparam logic [CUR_W-1:0] COLS_C  = CUR_W'(COLUMNS);
    localparam logic [COL_W-1:0] LASTCOL = COL_W'(COLUMNS - 1);

    logic [2:0]        state_reg, state_next;
    logic [CUR_W-1:0]  cnt_reg, cnt_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              wr_copy_reg, wr_copy_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;

    logic              op_reg, op_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic [CUR_W-1:0]  row_base_reg, row_base_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CHAR_W-1:0] cchar_reg, cchar_next;
    logic [CHAR_W-1:0] cattr_reg, cattr_next;

    logic              res_valid_reg, res_valid_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              upd_reg, upd_next;
    logic [CHAR_W-1:0] och_reg, och_next;
    logic [CHAR_W-1:0] oattr_reg, oattr_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_wa;
    logic [CELL_W-1:0] ram_wd;
    logic [ADDR_W-1:0] ram_ra;
    logic [CELL_W-1:0] ram_rd;

    logic [CUR_W-1:0]  cur_sum;
    logic [ADDR_W-1:0] cur_addr;
    logic [SUM_W-1:0]  rb_up;
    logic [CUR_W-1:0]  rb_dn;
    logic [CUR_W-1:0]  src_sum;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    assign cur_sum  = row_base_reg + CUR_W'(col_reg);
    assign cur_addr = ADDR_W'(cur_sum);
    assign rb_up    = SUM_W'(row_base_reg) + SUM_W'(COLUMNS);
    assign rb_dn    = row_base_reg - COLS_C;
    assign src_sum  = cnt_reg + COLS_C;

    assign cmd.ready         = (state_reg == ST_IDLE);
    assign res.valid         = res_valid_reg;
    assign res.cursor_pos    = pos_reg;
    assign res.cursor_update = upd_reg;
    assign res.cell_char     = och_reg;
    assign res.cell_attr     = oattr_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wr_pend_next   = 1'b0;
        wr_copy_next   = wr_copy_reg;
        wr_addr_next   = wr_addr_reg;
        op_next        = op_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        row_base_next  = row_base_reg;
        col_next       = col_reg;
        cchar_next     = cchar_reg;
        cattr_next     = cattr_reg;
        res_valid_next = res_valid_reg;
        pos_next       = pos_reg;
        upd_next       = upd_reg;
        och_next       = och_reg;
        oattr_next     = oattr_reg;

        ram_we = 1'b0;
        ram_wa = cur_addr;
        ram_wd = {ram_rd[CELL_W-1:CHAR_W], char_reg};
        ram_ra = cur_addr;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_wa = ADDR_W'(cnt_reg);
                ram_wd = BLANK_CELL;
                if (cnt_reg == CELLS_C - 1'b1)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.command;
                    char_next  = cmd.char_code;
                    last_next  = cmd.last_of_write;
                    idx_next   = cmd.cell_index;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                cchar_next = '0;
                cattr_next = '0;
                if (op_reg == CMD_READ)
                begin
                    ram_ra = ADDR_W'(idx_reg);
                    if (idx_reg < IDX_W'(CELLS))
                    begin
                        state_next = ST_RD_CAP;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    case (char_reg)
                        CHAR_NUL:
                        begin
                            state_next = ST_FINISH;
                        end
                        CHAR_LF:
                        begin
                            if (rb_up >= SUM_W'(CELLS))
                            begin
                                state_next = ST_SCROLL;
                            end
                            else
                            begin
                                row_base_next = CUR_W'(rb_up);
                                col_next      = '0;
                                state_next    = ST_FINISH;
                            end
                        end
                        CHAR_BS:
                        begin
                            if (cur_sum == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                if (col_reg == '0)
                                begin
                                    col_next      = LASTCOL;
                                    row_base_next = rb_dn;
                                end
                                else
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                                state_next = ST_PUT_RD;
                            end
                        end
                        default:
                        begin
                            if (row_base_reg == CELLS_C)
                            begin
                                state_next = ST_SCROLL;
                            end
                            else
                            begin
                                state_next = ST_PUT_RD;
                            end
                        end
                    endcase
                end
            end

            ST_SCROLL:
            begin
                // read of cell cnt+COLUMNS overlaps the write of the previous cell
                ram_we = wr_pend_reg;
                ram_wa = wr_addr_reg;
                ram_wd = wr_copy_reg ? ram_rd : BLANK_CELL;
                ram_ra = (cnt_reg < COPY_C) ? ADDR_W'(src_sum) : '0;
                if (cnt_reg == CELLS_C)
                begin
                    cnt_next      = '0;
                    row_base_next = COPY_C;
                    col_next      = '0;
                    if (char_reg == CHAR_LF)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_PUT_RD;
                    end
                end
                else
                begin
                    wr_pend_next = 1'b1;
                    wr_addr_next = ADDR_W'(cnt_reg);
                    wr_copy_next = (cnt_reg < COPY_C);
                    cnt_next     = cnt_reg + 1'b1;
                end
            end

            ST_PUT_RD:
            begin
                state_next = ST_PUT_WR;
            end

            ST_PUT_WR:
            begin
                ram_we = 1'b1;
                if (char_reg == CHAR_BS)
                begin
                    ram_wd = {ram_rd[CELL_W-1:CHAR_W], CHAR_NUL};
                end
                else if (col_reg == LASTCOL)
                begin
                    col_next      = '0;
                    row_base_next = CUR_W'(rb_up);
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
                state_next = ST_FINISH;
            end

            ST_RD_CAP:
            begin
                cchar_next = ram_rd[CHAR_W-1:0];
                cattr_next = ram_rd[CELL_W-1:CHAR_W];
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    pos_next       = POS_W'(cur_sum);
                    upd_next       = (op_reg == CMD_PUT) && last_reg;
                    och_next       = cchar_reg;
                    oattr_next     = cattr_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            row_base_reg  <= '0;
            col_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wr_pend_reg   <= wr_pend_next;
            row_base_reg  <= row_base_next;
            col_reg       <= col_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_copy_reg <= wr_copy_next;
        wr_addr_reg <= wr_addr_next;
        op_reg      <= op_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
        idx_reg     <= idx_next;
        cchar_reg   <= cchar_next;
        cattr_reg   <= cattr_next;
        pos_reg     <= pos_next;
        upd_reg     <= upd_next;
        och_reg     <= och_next;
        oattr_reg   <= oattr_next;
    end

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_sum <= CELLS_C) && (col_reg <= LASTCOL))
        else $error("cursor outside the screen");

    a_end_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (row_base_reg == CELLS_C) |-> (col_reg == '0))
        else $error("cursor past the end with non-zero column");

    a_res_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result loaded outside finish");

    a_put_wr_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT_WR) |=> (state_reg == ST_FINISH))
        else $error("cell write not followed by finish");

    a_scroll_write_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL && cnt_reg == '0) |-> !wr_pend_reg)
        else $error("stale pending write at scroll start");

endmodule
